// ===== rtl/core/ifrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_pkg
// Shared types and constants of the inverter fault retry supervisor.
// ----------------------------------------------------------------------------
package ifrs_pkg;

   localparam int NUM_INVERTERS = 4;
   localparam int NUM_CODES     = 5;
   localparam int CODE_W        = 16;
   localparam int OP_W          = 2;
   localparam int PHASE_W       = 2;
   localparam int REPORT_W      = 2;
   localparam int CSR_IDX_W     = 3;

   localparam logic [CODE_W-1:0] WINDOW_MAX = {CODE_W{1'b1}};

   // register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_RETRY_WINDOW = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_A    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_B    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_C    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_D    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOCKOUT_E    = 3'd5;

   localparam logic [CODE_W-1:0] RETRY_WINDOW_RESET = 16'd100;
   localparam logic [NUM_CODES-1:0][CODE_W-1:0] LOCKOUT_RESET = {
      16'd1100, 16'd3871, 16'd2311, 16'd1342, 16'd259
   };

   // request operations
   localparam logic [OP_W-1:0] OP_ENTER = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_EXIT  = 2'd2;

   // phase codes as seen on the result
   localparam logic [PHASE_W-1:0] PH_RETRY     = 2'd0;
   localparam logic [PHASE_W-1:0] PH_LOCKOUT   = 2'd1;
   localparam logic [PHASE_W-1:0] PH_RECOVERED = 2'd2;

   // vehicle state report codes
   localparam logic [REPORT_W-1:0] RPT_NONE       = 2'd0;
   localparam logic [REPORT_W-1:0] RPT_INV_FAULT  = 2'd1;
   localparam logic [REPORT_W-1:0] RPT_HARD_FAULT = 2'd2;

   typedef struct packed {
      logic [CODE_W-1:0]                   retry_window;
      logic [NUM_CODES-1:0][CODE_W-1:0]    lockout_codes;
   } cfg_type;

   typedef struct packed {
      logic [OP_W-1:0]                     operation;
      logic [NUM_INVERTERS-1:0]            fault_bits;
      logic [NUM_INVERTERS-1:0][CODE_W-1:0] codes;
   } req_type;

   typedef struct packed {
      logic [PHASE_W-1:0]       phase;
      logic                     cycle_active;
      logic [CODE_W-1:0]        window_count;
      logic [NUM_INVERTERS-1:0] reset_levels;
      logic                     alert;
   } state_type;

   typedef struct packed {
      logic [PHASE_W-1:0]       phase;
      logic [REPORT_W-1:0]      report;
      logic                     retry_alert;
      logic                     return_request;
      logic [NUM_INVERTERS-1:0] reset_levels;
      logic [NUM_INVERTERS-1:0] retry_start_mask;
   } rsp_type;

endpackage

// ===== rtl/core/ifrs_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_csr
// Configuration registers: retry window length and the five lockout codes.
// ----------------------------------------------------------------------------
module ifrs_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ifrs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ifrs_pkg::CODE_W-1:0]       csr_data,
   output ifrs_pkg::cfg_type                 cfg
);
   import ifrs_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_RETRY_WINDOW: cfg_in.retry_window     = csr_data;
            CSR_LOCKOUT_A:    cfg_in.lockout_codes[0] = csr_data;
            CSR_LOCKOUT_B:    cfg_in.lockout_codes[1] = csr_data;
            CSR_LOCKOUT_C:    cfg_in.lockout_codes[2] = csr_data;
            CSR_LOCKOUT_D:    cfg_in.lockout_codes[3] = csr_data;
            CSR_LOCKOUT_E:    cfg_in.lockout_codes[4] = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.retry_window  <= RETRY_WINDOW_RESET;
         cfg_ff.lockout_codes <= LOCKOUT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/core/ifrs_lockout_match.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_lockout_match
// Compares every inverter error code against all lockout codes.
// ----------------------------------------------------------------------------
module ifrs_lockout_match (
   input  logic [ifrs_pkg::NUM_INVERTERS-1:0][ifrs_pkg::CODE_W-1:0] codes,
   input  logic [ifrs_pkg::NUM_CODES-1:0][ifrs_pkg::CODE_W-1:0]     lockout_codes,
   output logic                                                     lock
);
   import ifrs_pkg::*;

   logic [NUM_INVERTERS-1:0][NUM_CODES-1:0] hit;

   always_comb begin
      for (int i = 0; i < NUM_INVERTERS; i++) begin
         for (int j = 0; j < NUM_CODES; j++) begin
            hit[i][j] = (codes[i] == lockout_codes[j]);
         end
      end
   end

   assign lock = |hit;

endmodule

// ===== rtl/core/ifrs_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_step
// Next supervisor state and result for one request.
// ----------------------------------------------------------------------------
module ifrs_step (
   input  ifrs_pkg::req_type   req,
   input  ifrs_pkg::cfg_type   cfg,
   input  ifrs_pkg::state_type cur,
   output ifrs_pkg::state_type nxt,
   output ifrs_pkg::rsp_type   rsp
);
   import ifrs_pkg::*;

   logic              lock;
   logic [CODE_W-1:0] count_inc;
   logic [REPORT_W-1:0]      report;
   logic                     ret_req;
   logic [NUM_INVERTERS-1:0] start_mask;

   ifrs_lockout_match u_match (
      .codes         (req.codes),
      .lockout_codes (cfg.lockout_codes),
      .lock          (lock)
   );

   // saturating window counter
   assign count_inc = (cur.window_count != WINDOW_MAX) ? cur.window_count + 1'b1
                                                       : cur.window_count;

   always_comb begin
      nxt        = cur;
      report     = RPT_NONE;
      ret_req    = 1'b0;
      start_mask = '0;
      unique case (req.operation)
         OP_ENTER: begin
            nxt.phase        = PH_RETRY;
            nxt.cycle_active = 1'b0;
            nxt.window_count = '0;
            nxt.alert        = 1'b1;
            report           = RPT_INV_FAULT;
         end
         OP_EXIT: begin
            nxt.alert        = 1'b0;
            nxt.reset_levels = '0;
            nxt.cycle_active = 1'b0;
            nxt.window_count = '0;
         end
         OP_TICK: begin
            if (cur.phase == PH_LOCKOUT) begin
               nxt.alert = 1'b0;
               report    = RPT_HARD_FAULT;
            end else if (cur.phase == PH_RECOVERED) begin
               nxt.alert = 1'b0;
               ret_req   = 1'b1;
            end else if (lock) begin
               nxt.reset_levels = '0;
               nxt.cycle_active = 1'b0;
               nxt.phase        = PH_LOCKOUT;
            end else if (req.fault_bits == '0) begin
               nxt.phase = PH_RECOVERED;
            end else if (!cur.cycle_active) begin
               start_mask       = req.fault_bits;
               nxt.reset_levels = cur.reset_levels | req.fault_bits;
               nxt.window_count = '0;
               nxt.cycle_active = 1'b1;
            end else begin
               nxt.window_count = count_inc;
               // a zero window expires on the first counted tick
               if (count_inc >= cfg.retry_window) begin
                  nxt.reset_levels = '0;
                  nxt.cycle_active = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp.phase            = nxt.phase;
      rsp.report           = report;
      rsp.retry_alert      = nxt.alert;
      rsp.return_request   = ret_req;
      rsp.reset_levels     = nxt.reset_levels;
      rsp.retry_start_mask = start_mask;
   end

endmodule

// ===== rtl/core/inverter_fault_retry_supervisor.sv =====
`timescale 1ns / 1ps
// Path: an accepted request passes through the request register and one
// combinational step into the result register, where its result is valid.
// Throughput: one request per cycle while rsp_ready holds; the supervisor state
// register updates in the same cycle a request moves into the result register.
// Reset: synchronous, clears the supervisor state and both pipeline valids and
// loads the default configuration; requests are taken right after reset.
// ----------------------------------------------------------------------------
// inverter_fault_retry_supervisor
// Retry supervisor for four motor inverters with lockout code check.
// ----------------------------------------------------------------------------
module inverter_fault_retry_supervisor (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [ifrs_pkg::OP_W-1:0]             req_operation,
   input  logic [ifrs_pkg::NUM_INVERTERS-1:0]    req_fault_bits,
   input  logic [ifrs_pkg::CODE_W-1:0]           req_code_front_left,
   input  logic [ifrs_pkg::CODE_W-1:0]           req_code_front_right,
   input  logic [ifrs_pkg::CODE_W-1:0]           req_code_rear_left,
   input  logic [ifrs_pkg::CODE_W-1:0]           req_code_rear_right,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [ifrs_pkg::PHASE_W-1:0]          rsp_phase,
   output logic [ifrs_pkg::REPORT_W-1:0]         rsp_vehicle_state_report,
   output logic                                  rsp_retry_alert,
   output logic                                  rsp_return_request,
   output logic [ifrs_pkg::NUM_INVERTERS-1:0]    rsp_reset_levels,
   output logic [ifrs_pkg::NUM_INVERTERS-1:0]    rsp_retry_start_mask,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [ifrs_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ifrs_pkg::CODE_W-1:0]           csr_data
);
   import ifrs_pkg::*;

   cfg_type   cfg;
   req_type   req_ff, req_in;
   logic      req_valid_ff, req_valid_in;
   state_type state_ff, state_nxt;
   rsp_type   rsp_ff, rsp_nxt;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      advance;
   logic      req_take;

   ifrs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ifrs_step u_step (
      .req (req_ff),
      .cfg (cfg),
      .cur (state_ff),
      .nxt (state_nxt),
      .rsp (rsp_nxt)
   );

   // request moves on when the result register is free or being drained
   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      req_in.operation  = req_operation;
      req_in.fault_bits = req_fault_bits;
      req_in.codes      = {req_code_rear_right, req_code_rear_left,
                           req_code_front_right, req_code_front_left};
   end

   assign req_valid_in = req_take || (req_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_RETRY, cycle_active: 1'b0, window_count: '0,
                           reset_levels: '0, alert: 1'b0};
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_nxt;
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_phase                = rsp_ff.phase;
   assign rsp_vehicle_state_report = rsp_ff.report;
   assign rsp_retry_alert          = rsp_ff.retry_alert;
   assign rsp_return_request       = rsp_ff.return_request;
   assign rsp_reset_levels         = rsp_ff.reset_levels;
   assign rsp_retry_start_mask     = rsp_ff.retry_start_mask;

endmodule

// ===== rtl/core/ifrs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ifrs_checker
// Port-level checks of the retry supervisor results.
// ----------------------------------------------------------------------------
module ifrs_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [ifrs_pkg::PHASE_W-1:0]          rsp_phase,
   input  logic [ifrs_pkg::REPORT_W-1:0]         rsp_vehicle_state_report,
   input  logic                                  rsp_retry_alert,
   input  logic                                  rsp_return_request,
   input  logic [ifrs_pkg::NUM_INVERTERS-1:0]    rsp_reset_levels,
   input  logic [ifrs_pkg::NUM_INVERTERS-1:0]    rsp_retry_start_mask
);
   import ifrs_pkg::*;

   // a return request only comes out of the recovered phase
   a_return_recovered: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_return_request |-> rsp_phase == PH_RECOVERED)
      else $error("return request outside recovered phase");

   // hard fault is reported only while locked out
   a_hard_fault_lockout: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vehicle_state_report == RPT_HARD_FAULT |-> rsp_phase == PH_LOCKOUT)
      else $error("hard fault report outside lockout");

   // a started retry drives reset on every inverter it names
   a_start_levels: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_retry_start_mask != '0 |->
         (rsp_reset_levels & rsp_retry_start_mask) == rsp_retry_start_mask
         && rsp_phase == PH_RETRY)
      else $error("retry start without matching reset levels");

   // entering raises the alert and restarts in the retry phase
   a_enter_alert: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_vehicle_state_report == RPT_INV_FAULT |->
         rsp_retry_alert && rsp_phase == PH_RETRY && rsp_retry_start_mask == '0)
      else $error("inverter fault report without alert");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_reset_levels)
         && $stable(rsp_phase))
      else $error("stalled response dropped or changed");

endmodule

bind inverter_fault_retry_supervisor ifrs_checker u_ifrs_checker (.*);
